// File: rtl/core/tpwl_pkg.sv
`default_nettype none

package tpwl_pkg;

   localparam int TABLE_DEPTH_DEF = 256;

   // Number of slots that an entry_index can reach
   localparam int INDEX_REACH = 256;

   localparam logic [15:0] WILDCARD = 16'hFFFF;

   // 4.1868 as unsigned Q3.20, carried signed for the multiply
   localparam logic signed [23:0] KJ_FACTOR = 24'sd4390178;
   localparam logic signed [39:0] ROUND_POS = 40'sd524288;
   localparam logic signed [39:0] ROUND_NEG = 40'sd524287;
   localparam logic signed [39:0] KJ_MAX = 40'sd262143;
   localparam logic signed [39:0] KJ_MIN = -40'sd262144;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_EMIT
   } state_type;

   function automatic logic end_ok(logic [15:0] stored, logic [15:0] query);
      return (stored == query) || (stored == WILDCARD);
   endfunction

   // Types: a in bits 15..0, b 31..16, c 47..32, d 63..48
   function automatic logic types_match(logic [63:0] entry, logic [63:0] query);
      logic fwd;
      logic rev;
      fwd = (entry[31:16] == query[31:16]) && (entry[47:32] == query[47:32]) &&
            end_ok(entry[15:0], query[15:0]) && end_ok(entry[63:48], query[63:48]);
      rev = (entry[47:32] == query[31:16]) && (entry[31:16] == query[47:32]) &&
            end_ok(entry[63:48], query[15:0]) && end_ok(entry[15:0], query[63:48]);
      return fwd || rev;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/tpwl_kj_conv.sv
`default_nettype none

module tpwl_kj_conv (
   input  wire                clock,
   input  wire  signed [15:0] kcal,
   output logic signed [18:0] kj
);

   logic signed [38:0] prod_ff;
   logic signed [38:0] prod_in;
   logic signed [39:0] rounded;
   logic signed [39:0] scaled;

   assign prod_in = 39'(kcal) * 39'(tpwl_pkg::KJ_FACTOR);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Round half away from zero, drop the 20 fraction bits, then clamp to 19-bit signed
   always_comb begin
      rounded = 40'(prod_ff) + (prod_ff[38] ? tpwl_pkg::ROUND_NEG : tpwl_pkg::ROUND_POS);
      scaled = rounded >>> 20;
      if (scaled > tpwl_pkg::KJ_MAX) begin
         kj = 19'(tpwl_pkg::KJ_MAX);
      end else if (scaled < tpwl_pkg::KJ_MIN) begin
         kj = 19'(tpwl_pkg::KJ_MIN);
      end else begin
         kj = scaled[18:0];
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/torsion_param_wildcard_lookup_unit.sv
// Torsion parameter table with wildcard lookup.
// req channel: tuser[0] is the operation (0 load, 1 lookup). A load writes
// slot entry_index of the type and parameter memories, if below TABLE_DEPTH,
// and gives no result. A lookup gives exactly one result on the rsp channel.
// csr_we/csr_wdata set entries_in_use, the number of slots a lookup scans;
// write it only while the block is idle.
// Flow: a lookup scans one memory entry per cycle through the single read
// port, stopping at the first match. A hit passes from the read register
// to the kJ multiply and then the result load into the result register; a
// miss takes an end-of-scan step after the last read (at once, if no entry
// is scanned) before the same two steps. At most min(entries_in_use,
// TABLE_DEPTH, 256) entries are read. One lookup is in progress at a time:
// the next item is accepted in the cycle after the result load.
// The result sits in an output register, so the next item is accepted
// while it waits; a new lookup stalls in its last step until the receiver
// takes the old result.
// Reset clears entries_in_use, the state machine and rsp_tvalid; the
// memory contents are kept and are undefined until loaded.
`default_nettype none

module torsion_param_wildcard_lookup_unit #(
   parameter int TABLE_DEPTH = tpwl_pkg::TABLE_DEPTH_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // entry_index[7:0], type_a[23:8], type_b[39:24], type_c[55:40],
   // type_d[71:56], middle_bond_type[74:72], force_constant_in[90:75],
   // phase_negative_in[91], zero[95:92]
   input  wire  [95:0] req_tdata,
   // operation[0]
   input  wire  [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // matched_entry[7:0], force_constant_kj[26:8], phase_negative[27],
   // zero[31:28]
   output logic [31:0] rsp_tdata,
   // found[0]
   output logic [0:0]  rsp_tuser,
   input  wire         csr_we,
   input  wire  [8:0]  csr_wdata
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int IW = (AW > 8) ? AW : 8;
   localparam int CW = (AW > 9) ? AW : 9;
   localparam int SCAN_CAP =
      (TABLE_DEPTH < tpwl_pkg::INDEX_REACH) ? TABLE_DEPTH : tpwl_pkg::INDEX_REACH;

   logic [63:0] type_mem [TABLE_DEPTH];
   logic [19:0] param_mem [TABLE_DEPTH];

   tpwl_pkg::state_type state_ff, state_in;

   logic [8:0]  entries_ff;
   logic [8:0]  scan_limit;
   logic [63:0] query_ff;
   logic [2:0]  bond_ff;
   logic [8:0]  count_ff;
   logic [8:0]  last_ff;
   logic        rd_valid_ff;
   logic [7:0]  rd_idx_ff;
   logic [63:0] type_rd_ff;
   logic [19:0] param_rd_ff;
   logic        found_ff;
   logic [7:0]  match_idx_ff;
   logic signed [15:0] kcal_ff;
   logic        phase_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff;
   logic        rsp_found_ff;

   logic        accept;
   logic        load_wr;
   logic        issue;
   logic        hit;
   logic        miss_done;
   logic        out_free;
   logic        emit;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic signed [18:0] kj;

   tpwl_kj_conv u_conv (
      .clock (clock),
      .kcal  (kcal_ff),
      .kj    (kj)
   );

   assign scan_limit = (entries_ff > 9'(SCAN_CAP)) ? 9'(SCAN_CAP) : entries_ff;
   assign accept = req_tvalid && req_tready;
   assign load_wr = accept && (req_tuser[0] == tpwl_pkg::OP_LOAD) &&
                    (13'(req_tdata[7:0]) < 13'(TABLE_DEPTH));
   assign wr_addr = AW'(IW'(req_tdata[7:0]));
   assign rd_addr = AW'(CW'(count_ff));
   assign hit = rd_valid_ff && (param_rd_ff[18:16] == bond_ff) &&
                tpwl_pkg::types_match(type_rd_ff, query_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tpwl_pkg::ST_IDLE: begin
            if (req_tvalid && (req_tuser[0] == tpwl_pkg::OP_LOOKUP)) begin
               state_in = tpwl_pkg::ST_SCAN;
            end
         end
         tpwl_pkg::ST_SCAN: begin
            if (hit || miss_done) begin
               state_in = tpwl_pkg::ST_MUL;
            end
         end
         tpwl_pkg::ST_MUL: begin
            state_in = tpwl_pkg::ST_EMIT;
         end
         tpwl_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = tpwl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tpwl_pkg::ST_IDLE;
         end
      endcase
   end

   // State outputs
   always_comb begin
      req_tready = 1'b0;
      issue = 1'b0;
      miss_done = 1'b0;
      emit = 1'b0;
      unique case (state_ff)
         tpwl_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         tpwl_pkg::ST_SCAN: begin
            issue = (count_ff < last_ff) && !hit;
            // all reads returned without a match
            miss_done = !rd_valid_ff && (count_ff == last_ff);
         end
         tpwl_pkg::ST_MUL: begin
         end
         tpwl_pkg::ST_EMIT: begin
            emit = out_free;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (load_wr) begin
         type_mem[wr_addr] <= req_tdata[71:8];
         param_mem[wr_addr] <= {req_tdata[91], req_tdata[74:72], req_tdata[90:75]};
      end
      type_rd_ff <= type_mem[rd_addr];
      param_rd_ff <= param_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpwl_pkg::ST_IDLE;
         entries_ff <= '0;
         rd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_valid_ff <= issue;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            entries_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         query_ff <= req_tdata[71:8];
         bond_ff <= req_tdata[74:72];
         last_ff <= scan_limit;
         count_ff <= '0;
      end else if (issue) begin
         count_ff <= 9'(count_ff + 9'd1);
      end
      rd_idx_ff <= count_ff[7:0];
      if (hit) begin
         found_ff <= 1'b1;
         match_idx_ff <= rd_idx_ff;
         kcal_ff <= param_rd_ff[15:0];
         phase_ff <= param_rd_ff[19];
      end else if (miss_done) begin
         found_ff <= 1'b0;
         match_idx_ff <= '0;
         kcal_ff <= '0;
         phase_ff <= 1'b0;
      end
      if (emit) begin
         rsp_data_ff <= {4'b0000, phase_ff, kj, match_idx_ff};
         rsp_found_ff <= found_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser[0] = rsp_found_ff;

   assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == tpwl_pkg::ST_SCAN))
      else $error("read returned outside of a scan");

   assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (9'(rd_idx_ff) < last_ff))
      else $error("scan read past the entry limit");

   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser[0] == tpwl_pkg::OP_LOOKUP)) |=>
         (state_ff == tpwl_pkg::ST_SCAN) && !rd_valid_ff)
      else $error("lookup did not start a clean scan");

   assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff && (state_ff == tpwl_pkg::ST_IDLE))
      else $error("result not loaded into output register");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_data_ff == '0))
      else $error("miss carries nonzero fields");

endmodule

`default_nettype wire
